// File: hdl/bamc_pkg.sv
// Shared types and constants of the Boolean/arithmetic mask converter.
package bamc_pkg;

    // Conversion direction, carried in the input tuser bit.
    typedef enum logic {
        CMD_B2A = 1'b0,
        CMD_A2B = 1'b1
    } bamc_cmd_t;

    // Carry rounds folded into one pipeline stage.
    localparam int ROUNDS_PER_STAGE = 8;

    // Control that travels alongside the data through every stage.
    typedef struct packed {
        logic      valid;
        bamc_cmd_t cmd;
    } bamc_ctl_t;

endpackage

// File: hdl/boolean_arithmetic_mask_converter_unit.sv
// Top level of the pipelined Boolean/arithmetic mask converter.
//
// Usage: each transfer on the slave channel carries one first-order masked
// word, its mask r and a fresh random word g; s_tuser selects the direction
// (0: Boolean to arithmetic, 1: arithmetic to Boolean). Each input transfer
// produces exactly one transfer on the master channel holding the new share,
// in the same order as the inputs were taken.
// The path from input transfer to m_tvalid runs through one set-up stage, one
// stage per eight rounds of the carry recurrence, and one output stage. Both
// directions take the same path, so order is kept without reordering logic.
// One word is taken per cycle unless the receiver stalls; every stage register
// takes a new word whenever it is empty or its successor is taking its contents.
// Synchronous active-low reset clears all stage valid bits; the block then
// accepts input at once. When the receiver stalls, the pipeline keeps
// accepting until every stage is full, then s_tready drops; nothing is lost
// or repeated, and the result on m_tdata holds until it is taken.
module boolean_arithmetic_mask_converter_unit
    import bamc_pkg::*;
#(
    parameter int WORD_BITS = 64
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // Fields from bit 0 up: masked_word, mask_word, fresh_random, zero padding.
    input  logic [((3*WORD_BITS+7)/8)*8-1:0]       s_tdata,
    // Field: command.
    input  logic                                   s_tuser,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // Fields from bit 0 up: converted_word, zero padding.
    output logic [((WORD_BITS+7)/8)*8-1:0]         m_tdata
);

    localparam int NUM_ROUND_STAGES = (WORD_BITS - 1 + ROUNDS_PER_STAGE - 1) / ROUNDS_PER_STAGE;
    localparam int OUT_BITS         = ((WORD_BITS + 7) / 8) * 8;

    // Stage interconnect: index 0 is the set-up stage output, index j+1 the
    // output of round stage j.
    bamc_ctl_t            st_ctl   [0:NUM_ROUND_STAGES];
    logic                 st_ready [0:NUM_ROUND_STAGES+1];
    logic [WORD_BITS-1:0] st_a     [0:NUM_ROUND_STAGES];
    logic [WORD_BITS-1:0] st_r     [0:NUM_ROUND_STAGES];
    logic [WORD_BITS-1:0] st_om    [0:NUM_ROUND_STAGES];
    logic [WORD_BITS-1:0] st_t     [0:NUM_ROUND_STAGES];
    logic [WORD_BITS-1:0] st_res   [0:NUM_ROUND_STAGES];

    bamc_ctl_t            in_ctl;
    logic [WORD_BITS-1:0] result_word;
    logic [NUM_ROUND_STAGES+1:0] stage_valid;

    assign in_ctl.valid = s_tvalid;
    assign in_ctl.cmd   = bamc_cmd_t'(s_tuser);

    bamc_prep #(
        .WORD_BITS (WORD_BITS)
    ) u_prep (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .up_ctl     (in_ctl),
        .up_ready   (st_ready[0]),
        .up_word    (s_tdata[WORD_BITS-1:0]),
        .up_mask    (s_tdata[2*WORD_BITS-1:WORD_BITS]),
        .up_rand    (s_tdata[3*WORD_BITS-1:2*WORD_BITS]),
        .down_ctl   (st_ctl[0]),
        .down_ready (st_ready[1]),
        .down_a     (st_a[0]),
        .down_r     (st_r[0]),
        .down_om    (st_om[0]),
        .down_t     (st_t[0]),
        .down_res   (st_res[0])
    );

    for (genvar j = 0; j < NUM_ROUND_STAGES; j++) begin : g_round
        // The last stage takes whatever rounds remain.
        localparam int REMAIN = WORD_BITS - 1 - j * ROUNDS_PER_STAGE;
        localparam int ROUNDS = (REMAIN < ROUNDS_PER_STAGE) ? REMAIN : ROUNDS_PER_STAGE;

        bamc_round_stage #(
            .WORD_BITS (WORD_BITS),
            .ROUNDS    (ROUNDS)
        ) u_stage (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .up_ctl     (st_ctl[j]),
            .up_ready   (st_ready[j+1]),
            .up_a       (st_a[j]),
            .up_r       (st_r[j]),
            .up_om      (st_om[j]),
            .up_t       (st_t[j]),
            .up_res     (st_res[j]),
            .down_ctl   (st_ctl[j+1]),
            .down_ready (st_ready[j+2]),
            .down_a     (st_a[j+1]),
            .down_r     (st_r[j+1]),
            .down_om    (st_om[j+1]),
            .down_t     (st_t[j+1]),
            .down_res   (st_res[j+1])
        );
    end

    bamc_out #(
        .WORD_BITS (WORD_BITS)
    ) u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .up_ctl    (st_ctl[NUM_ROUND_STAGES]),
        .up_ready  (st_ready[NUM_ROUND_STAGES+1]),
        .up_a      (st_a[NUM_ROUND_STAGES]),
        .up_r      (st_r[NUM_ROUND_STAGES]),
        .up_t      (st_t[NUM_ROUND_STAGES]),
        .up_res    (st_res[NUM_ROUND_STAGES]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_word  (result_word)
    );

    assign s_tready = st_ready[0];
    assign m_tdata  = OUT_BITS'(result_word);

    // Occupancy of every stage, used by the checks below.
    always_comb begin
        for (int i = 0; i <= NUM_ROUND_STAGES; i++) begin
            stage_valid[i] = st_ctl[i].valid;
        end
        stage_valid[NUM_ROUND_STAGES+1] = m_tvalid;
    end

    // After reset the output stage must be empty.
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result presented straight after reset");

    // An empty output stage means every stage can move, so input is taken.
    assert property (@(posedge aclk) disable iff (!aresetn) !m_tvalid |-> s_tready)
        else $error("input refused while the output stage is empty");

    // With every stage full and the receiver stalled, input must be refused.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (&stage_valid) && !m_tready |-> !s_tready)
        else $error("input accepted into a full, stalled pipeline");

endmodule

// File: hdl/bamc_prep.sv
// First stage: Boolean-to-arithmetic first half and carry recurrence set-up.
module bamc_prep
    import bamc_pkg::*;
#(
    parameter int WORD_BITS = 64
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  bamc_ctl_t            up_ctl,
    output logic                 up_ready,
    input  logic [WORD_BITS-1:0] up_word,
    input  logic [WORD_BITS-1:0] up_mask,
    input  logic [WORD_BITS-1:0] up_rand,
    output bamc_ctl_t            down_ctl,
    input  logic                 down_ready,
    output logic [WORD_BITS-1:0] down_a,
    output logic [WORD_BITS-1:0] down_r,
    output logic [WORD_BITS-1:0] down_om,
    output logic [WORD_BITS-1:0] down_t,
    output logic [WORD_BITS-1:0] down_res
);

    bamc_ctl_t            ctl_reg;
    logic [WORD_BITS-1:0] a_reg, r_reg, om_reg, t_reg, res_reg;
    logic [WORD_BITS-1:0] a_next, r_next, om_next, t_next, res_next;
    logic [WORD_BITS-1:0] h, g_shift, a2b_res;

    assign up_ready = !ctl_reg.valid || down_ready;
    assign h        = up_rand ^ up_mask;
    assign g_shift  = {up_rand[WORD_BITS-2:0], 1'b0};
    assign a2b_res  = g_shift ^ up_word;

    always_comb begin
        if (up_ctl.cmd == CMD_B2A) begin
            // The second subtraction, (s ^ h) - h, is finished at the output.
            t_next   = ((up_word ^ up_rand) - up_rand) ^ up_word;
            a_next   = up_word ^ h;
            r_next   = h;
            om_next  = '0;
            res_next = '0;
        end else begin
            t_next   = g_shift;
            a_next   = up_word;
            r_next   = up_mask;
            res_next = a2b_res;
            om_next  = (up_rand & h) ^ ((up_rand ^ a2b_res) & up_mask) ^ (g_shift & up_word);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else if (up_ready) begin
            ctl_reg <= up_ctl;
        end
    end

    always_ff @(posedge aclk) begin
        if (up_ready && up_ctl.valid) begin
            a_reg   <= a_next;
            r_reg   <= r_next;
            om_reg  <= om_next;
            t_reg   <= t_next;
            res_reg <= res_next;
        end
    end

    assign down_ctl = ctl_reg;
    assign down_a   = a_reg;
    assign down_r   = r_reg;
    assign down_om  = om_reg;
    assign down_t   = t_reg;
    assign down_res = res_reg;

endmodule

// File: hdl/bamc_round_stage.sv
// Pipeline stage running a group of carry rounds of the arithmetic-to-Boolean conversion.
module bamc_round_stage
    import bamc_pkg::*;
#(
    parameter int WORD_BITS = 64,
    parameter int ROUNDS    = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  bamc_ctl_t            up_ctl,
    output logic                 up_ready,
    input  logic [WORD_BITS-1:0] up_a,
    input  logic [WORD_BITS-1:0] up_r,
    input  logic [WORD_BITS-1:0] up_om,
    input  logic [WORD_BITS-1:0] up_t,
    input  logic [WORD_BITS-1:0] up_res,
    output bamc_ctl_t            down_ctl,
    input  logic                 down_ready,
    output logic [WORD_BITS-1:0] down_a,
    output logic [WORD_BITS-1:0] down_r,
    output logic [WORD_BITS-1:0] down_om,
    output logic [WORD_BITS-1:0] down_t,
    output logic [WORD_BITS-1:0] down_res
);

    bamc_ctl_t            ctl_reg;
    logic [WORD_BITS-1:0] a_reg, r_reg, om_reg, t_reg, res_reg;
    logic [WORD_BITS-1:0] t_next, t_iter, u;

    assign up_ready = !ctl_reg.valid || down_ready;

    // Each round: t <= ((t & r) ^ om ^ (t & a)) << 1.
    always_comb begin
        t_iter = up_t;
        u      = '0;
        for (int k = 0; k < ROUNDS; k++) begin
            u      = (t_iter & up_r) ^ up_om ^ (t_iter & up_a);
            t_iter = {u[WORD_BITS-2:0], 1'b0};
        end
        t_next = (up_ctl.cmd == CMD_A2B) ? t_iter : up_t;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else if (up_ready) begin
            ctl_reg <= up_ctl;
        end
    end

    always_ff @(posedge aclk) begin
        if (up_ready && up_ctl.valid) begin
            a_reg   <= up_a;
            r_reg   <= up_r;
            om_reg  <= up_om;
            t_reg   <= t_next;
            res_reg <= up_res;
        end
    end

    assign down_ctl = ctl_reg;
    assign down_a   = a_reg;
    assign down_r   = r_reg;
    assign down_om  = om_reg;
    assign down_t   = t_reg;
    assign down_res = res_reg;

endmodule

// File: hdl/bamc_out.sv
// Output stage: final combine of either conversion into the result register.
module bamc_out
    import bamc_pkg::*;
#(
    parameter int WORD_BITS = 64
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  bamc_ctl_t            up_ctl,
    output logic                 up_ready,
    input  logic [WORD_BITS-1:0] up_a,
    input  logic [WORD_BITS-1:0] up_r,
    input  logic [WORD_BITS-1:0] up_t,
    input  logic [WORD_BITS-1:0] up_res,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [WORD_BITS-1:0] out_word
);

    logic                 valid_reg;
    logic [WORD_BITS-1:0] word_reg, word_next;

    assign up_ready = !valid_reg || out_ready;

    always_comb begin
        if (up_ctl.cmd == CMD_A2B) begin
            word_next = up_res ^ up_t;
        end else begin
            word_next = (up_a - up_r) ^ up_t;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (up_ready) begin
            valid_reg <= up_ctl.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (up_ready && up_ctl.valid) begin
            word_reg <= word_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule
